// ----- sv/tsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone sequence player package
// Shared widths, request and status codes, the note ROM and small arithmetic
// helpers for the buzzer pattern player.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // Sizes of the pattern store.
  localparam int MaxNotes     = 4;
  localparam int PatternCount = 20;
  localparam int RomPatterns  = 20;
  localparam int RomNotes     = 4;

  // Field widths.
  localparam int ReqW   = 2;
  localparam int PatW   = 5;
  localparam int IdxW   = 2;
  localparam int LenW   = 3;
  localparam int VarInW = 8;
  localparam int FreqW  = 11;
  localparam int DutyW  = 10;
  localparam int ToneW  = 9;
  localparam int GapW   = 11;
  localparam int MsW    = 11;
  localparam int PctW   = 7;
  localparam int ProdW  = FreqW + PctW;
  localparam int CfgIdxW = 1;

  // Division by 100 as a multiply by a rounded-up reciprocal; exact for
  // every product below 2^ProdW.
  localparam int RecipW   = 19;
  localparam int DivShift = 25;
  localparam int QuotW    = ProdW + RecipW - DivShift;
  localparam logic [RecipW-1:0] DivRecip = 19'd335545;

  localparam logic [PatW-1:0]  PatIdle  = 5'd0;
  localparam logic [PatW-1:0]  PatAlarm = 5'd1;
  localparam logic [PatW-1:0]  PatHatch = 5'd2;
  localparam logic [FreqW-1:0] FreqMax  = 11'd2047;
  localparam logic [PctW-1:0]  PctUnity       = 7'd100;
  localparam logic [PctW-1:0]  ScaleUpReset   = 7'd106;
  localparam logic [PctW-1:0]  ScaleDownReset = 7'd94;

  typedef enum logic [ReqW-1:0] {
    ReqTick    = 2'd0,
    ReqOneShot = 2'd1,
    ReqStop    = 2'd2,
    ReqAlarm   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    VarPlain = 2'd0,
    VarUp    = 2'd1,
    VarDown  = 2'd2
  } variant_e;

  typedef enum logic {
    StatusOk      = 1'b0,
    StatusInvalid = 1'b1
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgScaleUp   = 1'b0,
    CfgScaleDown = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic [ToneW-1:0] tone_ms;
    logic [GapW-1:0]  gap_ms;
    logic [DutyW-1:0] duty;
  } note_t;

  // Number of notes in each pattern.
  localparam logic [LenW-1:0] PatLen [RomPatterns] = '{
    3'd0, 3'd3, 3'd3, 3'd4, 3'd2, 3'd3, 3'd4, 3'd3, 3'd2, 3'd3,
    3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd1
  };

  // Notes: frequency, tone time, gap time, duty.
  localparam note_t NoteRom [RomPatterns][RomNotes] = '{
    '{'{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
    '{'{1047, 140, 60, 256}, '{1319, 140, 60, 256}, '{1568, 220, 1200, 256},
      '{0, 0, 0, 0}},
    '{'{784, 110, 70, 140}, '{988, 130, 70, 140}, '{1319, 260, 0, 160},
      '{0, 0, 0, 0}},
    '{'{1568, 35, 25, 75}, '{1175, 55, 45, 90}, '{1568, 35, 25, 75},
      '{1175, 70, 0, 90}},
    '{'{1047, 55, 40, 80}, '{1175, 90, 0, 85}, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
    '{'{784, 65, 40, 80}, '{988, 75, 40, 90}, '{1175, 120, 0, 95},
      '{0, 0, 0, 0}},
    '{'{988, 50, 30, 100}, '{1319, 55, 30, 110}, '{1568, 70, 30, 115},
      '{1319, 100, 0, 105}},
    '{'{988, 65, 40, 90}, '{784, 90, 45, 80}, '{659, 130, 0, 75},
      '{0, 0, 0, 0}},
    '{'{1175, 55, 35, 80}, '{1319, 75, 0, 85}, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
    '{'{988, 55, 30, 85}, '{1175, 65, 30, 90}, '{1319, 90, 0, 95},
      '{0, 0, 0, 0}},
    '{'{988, 55, 30, 90}, '{1319, 65, 30, 100}, '{1568, 95, 0, 105},
      '{0, 0, 0, 0}},
    '{'{784, 90, 55, 85}, '{988, 70, 45, 90}, '{784, 120, 0, 80},
      '{0, 0, 0, 0}},
    '{'{784, 100, 55, 75}, '{659, 150, 0, 70}, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
    '{'{784, 85, 55, 75}, '{698, 110, 55, 72}, '{587, 160, 0, 68},
      '{0, 0, 0, 0}},
    '{'{1175, 45, 25, 90}, '{1568, 55, 35, 100}, '{1319, 85, 0, 95},
      '{0, 0, 0, 0}},
    '{'{784, 70, 35, 80}, '{988, 90, 35, 90}, '{1175, 130, 0, 95},
      '{0, 0, 0, 0}},
    '{'{1175, 40, 25, 95}, '{1568, 45, 25, 110}, '{1760, 55, 25, 115},
      '{1568, 75, 0, 105}},
    '{'{988, 100, 55, 85}, '{784, 120, 55, 80}, '{659, 180, 0, 70},
      '{0, 0, 0, 0}},
    '{'{659, 75, 45, 80}, '{988, 90, 45, 90}, '{1319, 140, 0, 100},
      '{0, 0, 0, 0}},
    '{'{784, 110, 0, 72}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}}
  };

  // Note lookup; a pattern id past the store reads the empty pattern.
  function automatic note_t note_at(logic [PatW-1:0] pat, logic [IdxW-1:0] idx);
    note_t n;
    if (pat >= PatW'(RomPatterns)) begin
      n = NoteRom[0][idx];
    end else begin
      n = NoteRom[pat][idx];
    end
    return n;
  endfunction

  // Playable length of a pattern, zero for ids outside the store.
  function automatic logic [LenW-1:0] pattern_len(logic [PatW-1:0] pat);
    logic [LenW-1:0] len;
    if (pat >= PatW'(RomPatterns) || pat >= PatW'(PatternCount)) begin
      len = '0;
    end else begin
      len = PatLen[pat];
      if (len > LenW'(MaxNotes)) begin
        len = LenW'(MaxNotes);
      end
    end
    return len;
  endfunction

  // Residue modulo 3 from the sum of base-4 digits, since 4 is 1 modulo 3.
  function automatic variant_e variant_mod3(logic [VarInW-1:0] v);
    logic [3:0] s;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    if (s >= 4'd9) s = s - 4'd9;
    if (s >= 4'd6) s = s - 4'd6;
    if (s >= 4'd3) s = s - 4'd3;
    return variant_e'(s[1:0]);
  endfunction

  // Product divided by 100, saturated to the frequency range.
  function automatic logic [FreqW-1:0] div100_sat(logic [ProdW-1:0] x);
    logic [ProdW+RecipW-1:0] p;
    logic [QuotW-1:0]        q;
    p = (ProdW+RecipW)'(x) * (ProdW+RecipW)'(DivRecip);
    q = p[ProdW+RecipW-1:DivShift];
    return (q > QuotW'(FreqMax)) ? FreqMax : q[FreqW-1:0];
  endfunction

endpackage

// ----- sv/tsp_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone sequence player request channel
// Valid/ready channel carrying one request: tick, one-shot, stop or alarm.
// ----------------------------------------------------------------------------
interface tsp_req_if;
  logic                         valid;
  logic                         ready;
  tsp_pkg::req_e                req_type;
  logic [tsp_pkg::PatW-1:0]     pattern_id;
  logic [tsp_pkg::VarInW-1:0]   variant;

  modport source (output valid, output req_type, output pattern_id, output variant,
                  input ready);
  modport sink   (input valid, input req_type, input pattern_id, input variant,
                  output ready);
endinterface

// ----- sv/tsp_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone sequence player result channel
// Valid/ready channel carrying the tone settings after each request.
// ----------------------------------------------------------------------------
interface tsp_res_if;
  logic                         valid;
  logic                         ready;
  logic                         tone_on;
  logic [tsp_pkg::FreqW-1:0]    tone_frequency;
  logic [tsp_pkg::DutyW-1:0]    tone_duty;
  logic [tsp_pkg::PatW-1:0]     active_pattern;
  tsp_pkg::status_e             status;

  modport source (output valid, output tone_on, output tone_frequency,
                  output tone_duty, output active_pattern, output status,
                  input ready);
  modport sink   (input valid, input tone_on, input tone_frequency,
                  input tone_duty, input active_pattern, input status,
                  output ready);
endinterface

// ----- sv/tone_sequence_player.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone sequence player
// Steps buzzer note patterns from a fixed ROM on millisecond ticks and play
// requests, and reports tone enable, frequency, duty, pattern and status.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   req_i     in         req_type, pattern_id, variant
//   res_o     out        tone_on, tone_frequency, tone_duty, active_pattern,
//                        status
//   cfg       in         cfg_we_i, cfg_index_i, cfg_wdata_i (percent factors)
//
// One transaction is taken every cycle while no result waits on res_o; its
// result is registered through the player state, note ROM and multiply, and
// divide by 100 stages into the output register. Reset clears the player to
// idle and loads the percent factors with 106 and 94. While a result waits on
// res_o the whole pipe holds and req_i.ready is low.
// ----------------------------------------------------------------------------
module tone_sequence_player (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tsp_pkg::PctW-1:0]      cfg_wdata_i,
  tsp_req_if.sink                       req_i,
  tsp_res_if.source                     res_o
);

  typedef struct packed {
    logic                       start;
    logic [tsp_pkg::PatW-1:0]   pat;
    logic [tsp_pkg::IdxW-1:0]   idx;
    logic                       in_gap;
    tsp_pkg::variant_e          pvar;
    tsp_pkg::status_e           status;
  } stage1_t;

  typedef struct packed {
    logic                       start;
    logic                       active;
    logic                       tone_on;
    logic [tsp_pkg::ProdW-1:0]  prod;
    logic [tsp_pkg::DutyW-1:0]  duty;
    logic [tsp_pkg::PatW-1:0]   pat;
    tsp_pkg::status_e           status;
  } stage2_t;

  // Configuration and player state.
  logic [tsp_pkg::PctW-1:0]   scale_up_q, scale_down_q;
  logic [tsp_pkg::PatW-1:0]   cur_pat_q, cur_pat_d;
  logic [tsp_pkg::IdxW-1:0]   note_idx_q, note_idx_d;
  logic                       in_gap_q, in_gap_d;
  logic [tsp_pkg::MsW-1:0]    ms_rem_q, ms_rem_d;
  tsp_pkg::variant_e          pitch_var_q, pitch_var_d;
  logic [tsp_pkg::FreqW-1:0]  scaled_q, scaled_d;

  // Pipeline registers.
  logic     s1_valid_q, s2_valid_q, out_valid_q;
  stage1_t  s1_q, s1_d;
  stage2_t  s2_q, s2_d;

  logic                       advance, accept;
  logic                       start;
  logic [tsp_pkg::IdxW-1:0]   start_idx;
  tsp_pkg::status_e           status;
  tsp_pkg::note_t             note_cur, note_start, note_s2;
  logic [tsp_pkg::LenW-1:0]   idx_next;
  logic [tsp_pkg::MsW-1:0]    ms_dec;
  logic [tsp_pkg::PctW-1:0]   pct;

  // The pipe moves whenever the output register is free or being emptied.
  assign advance     = !out_valid_q || res_o.ready;
  assign accept      = req_i.valid && advance;
  assign req_i.ready = advance;
  assign res_o.valid = out_valid_q;

  // Percent factor registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_up_q   <= tsp_pkg::ScaleUpReset;
      scale_down_q <= tsp_pkg::ScaleDownReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == tsp_pkg::CfgScaleUp) begin
        scale_up_q <= cfg_wdata_i;
      end else begin
        scale_down_q <= cfg_wdata_i;
      end
    end
  end

  // Player next state for the request at the input.
  always_comb begin
    cur_pat_d   = cur_pat_q;
    note_idx_d  = note_idx_q;
    in_gap_d    = in_gap_q;
    ms_rem_d    = ms_rem_q;
    pitch_var_d = pitch_var_q;
    start       = 1'b0;
    start_idx   = '0;
    status      = tsp_pkg::StatusOk;
    note_cur    = tsp_pkg::note_at(cur_pat_q, note_idx_q);
    idx_next    = tsp_pkg::LenW'(note_idx_q) + 1'b1;
    ms_dec      = (ms_rem_q != '0) ? ms_rem_q - 1'b1 : '0;

    unique case (req_i.req_type)
      tsp_pkg::ReqTick: begin
        if (cur_pat_q != tsp_pkg::PatIdle) begin
          ms_rem_d = ms_dec;
          if (ms_dec == '0) begin
            // Phase end: tone into gap, else next note, wrap or finish.
            priority if (!in_gap_q && note_cur.gap_ms != '0) begin
              in_gap_d = 1'b1;
              ms_rem_d = note_cur.gap_ms;
            end else if (idx_next < tsp_pkg::pattern_len(cur_pat_q)) begin
              start     = 1'b1;
              start_idx = idx_next[tsp_pkg::IdxW-1:0];
            end else if (cur_pat_q == tsp_pkg::PatAlarm) begin
              start = 1'b1;
            end else begin
              cur_pat_d  = tsp_pkg::PatIdle;
              note_idx_d = '0;
              in_gap_d   = 1'b0;
              ms_rem_d   = '0;
            end
          end
        end
      end
      tsp_pkg::ReqOneShot: begin
        priority if (req_i.pattern_id == tsp_pkg::PatIdle) begin
          status = tsp_pkg::StatusOk;
        end else if (req_i.pattern_id == tsp_pkg::PatAlarm ||
                     req_i.pattern_id == tsp_pkg::PatHatch ||
                     tsp_pkg::pattern_len(req_i.pattern_id) == '0) begin
          status = tsp_pkg::StatusInvalid;
        end else if (req_i.pattern_id != cur_pat_q) begin
          cur_pat_d   = req_i.pattern_id;
          pitch_var_d = tsp_pkg::variant_mod3(req_i.variant);
          start       = 1'b1;
        end else begin
          status = tsp_pkg::StatusOk;
        end
      end
      tsp_pkg::ReqStop: begin
        cur_pat_d  = tsp_pkg::PatIdle;
        note_idx_d = '0;
        in_gap_d   = 1'b0;
        ms_rem_d   = '0;
      end
      tsp_pkg::ReqAlarm: begin
        if (cur_pat_q != tsp_pkg::PatAlarm) begin
          cur_pat_d   = tsp_pkg::PatAlarm;
          pitch_var_d = tsp_pkg::VarPlain;
          start       = 1'b1;
        end
      end
      default: begin
        status = tsp_pkg::StatusOk;
      end
    endcase

    // Starting a note loads its tone time.
    note_start = tsp_pkg::note_at(cur_pat_d, start_idx);
    if (start) begin
      note_idx_d = start_idx;
      in_gap_d   = 1'b0;
      ms_rem_d   = tsp_pkg::MsW'(note_start.tone_ms);
    end

    s1_d.start  = start;
    s1_d.pat    = cur_pat_d;
    s1_d.idx    = note_idx_d;
    s1_d.in_gap = in_gap_d;
    s1_d.pvar   = pitch_var_d;
    s1_d.status = status;
  end

  // Player state registers change only on an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_pat_q   <= tsp_pkg::PatIdle;
      note_idx_q  <= '0;
      in_gap_q    <= 1'b0;
      ms_rem_q    <= '0;
      pitch_var_q <= tsp_pkg::VarPlain;
    end else if (accept) begin
      cur_pat_q   <= cur_pat_d;
      note_idx_q  <= note_idx_d;
      in_gap_q    <= in_gap_d;
      ms_rem_q    <= ms_rem_d;
      pitch_var_q <= pitch_var_d;
    end
  end

  // Second stage: note lookup and frequency times percent factor.
  always_comb begin
    note_s2 = tsp_pkg::note_at(s1_q.pat, s1_q.idx);
    unique case (s1_q.pvar)
      tsp_pkg::VarUp:   pct = scale_up_q;
      tsp_pkg::VarDown: pct = scale_down_q;
      default:          pct = tsp_pkg::PctUnity;
    endcase
    s2_d.start   = s1_q.start;
    s2_d.active  = s1_q.pat != tsp_pkg::PatIdle;
    s2_d.tone_on = s2_d.active && !s1_q.in_gap;
    s2_d.prod    = tsp_pkg::ProdW'(note_s2.freq) * tsp_pkg::ProdW'(pct);
    s2_d.duty    = s2_d.tone_on ? note_s2.duty : '0;
    s2_d.pat     = s1_q.pat;
    s2_d.status  = s1_q.status;
  end

  // Third stage: divide by 100 when a note starts, else keep the held value.
  assign scaled_d = s2_q.start ? tsp_pkg::div100_sat(s2_q.prod) : scaled_q;

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      scaled_q    <= '0;
    end else if (advance) begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
      if (s2_valid_q) begin
        scaled_q <= scaled_d;
      end
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      if (s2_valid_q) begin
        res_o.tone_on        <= s2_q.tone_on;
        res_o.tone_frequency <= s2_q.active ? scaled_d : '0;
        res_o.tone_duty      <= s2_q.duty;
        res_o.active_pattern <= s2_q.pat;
        res_o.status         <= s2_q.status;
      end
    end
  end

endmodule

// ----- sv/tsp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone sequence player checker
// Port-level assertions on the result channel and flow control.
// ----------------------------------------------------------------------------
module tsp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_ready_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic                        tone_on_i,
  input logic [tsp_pkg::FreqW-1:0]   tone_frequency_i,
  input logic [tsp_pkg::DutyW-1:0]   tone_duty_i,
  input logic [tsp_pkg::PatW-1:0]    active_pattern_i,
  input logic                        status_i
);

  // A stalled result transaction holds until it is taken.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      res_valid_i && !res_ready_i |=> res_valid_i && $stable(tone_on_i) &&
      $stable(tone_frequency_i) && $stable(tone_duty_i) &&
      $stable(active_pattern_i) && $stable(status_i))
    else $error("result changed while stalled");

  // Requests are refused only while a result is stalled.
  a_ready_only_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !req_ready_i |-> res_valid_i && !res_ready_i)
    else $error("request refused without output stall");

  // An idle player reports silence.
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
      res_valid_i && active_pattern_i == tsp_pkg::PatIdle |->
      !tone_on_i && tone_frequency_i == '0 && tone_duty_i == '0)
    else $error("idle player reports a tone");

  // A silent gap carries no duty.
  a_gap_no_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      res_valid_i && !tone_on_i |-> tone_duty_i == '0)
    else $error("duty set while tone is off");

endmodule

bind tone_sequence_player tsp_checker u_tsp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_ready_i      (req_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .tone_on_i        (res_o.tone_on),
  .tone_frequency_i (res_o.tone_frequency),
  .tone_duty_i      (res_o.tone_duty),
  .active_pattern_i (res_o.active_pattern),
  .status_i         (res_o.status)
);
